### sv/tga_pkg.sv
`timescale 1ns / 1ps
package tga_pkg;
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SIG   = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [7:0] RUN_FLAG = 8'd128;
   localparam logic [7:0] RUN_BIAS = 8'd127;
   localparam logic [3:0] SIG_LAST = 4'd11;
   localparam logic [2:0] HDR_LAST = 3'd5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic [2:0]  status;
      logic        image_done;
      logic        last_of_input;
   } rsp_type;

   // one classified item: up to two results
   typedef struct packed {
      logic    first_vld;
      rsp_type first;
      logic    second_vld;
      rsp_type second;
   } job_type;

   function automatic rsp_type error_rsp(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.status = st;
      return r;
   endfunction
endpackage

### sv/tga_if.sv
`timescale 1ns / 1ps
interface tga_req_if;
   import tga_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface tga_rsp_if;
   import tga_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

### sv/tga_front.sv
`timescale 1ns / 1ps
module tga_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tga_pkg::req_type  in_item,
   output logic              job_valid,
   input  logic              job_ready,
   output tga_pkg::job_type  job
);
   import tga_pkg::*;

   localparam logic [2:0] PH_SIG    = 3'd0;
   localparam logic [2:0] PH_HDR    = 3'd1;
   localparam logic [2:0] PH_RAW    = 3'd2;
   localparam logic [2:0] PH_PKTHDR = 3'd3;
   localparam logic [2:0] PH_PKTPIX = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_ERR    = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic        comp_ff, comp_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic        alpha_ff, alpha_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic        run_ff, run_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] colour_ff, colour_in;
   // product of width and height is loaded in the cycle after the header
   logic        mul_pend_ff, mul_pend_in;
   logic [31:0] prod_ff;

   logic [7:0]  b;
   logic        eof, accept, pix_done, erred;
   logic [23:0] colour_next;
   logic [7:0]  pix_alpha;
   rsp_type     r0, r1;
   logic        v0, v1;

   assign b = in_item.data_byte;
   assign eof = in_item.end_of_file;
   assign in_ready = job_ready && !mul_pend_ff;
   assign accept = in_valid && in_ready;

   always_comb begin
      colour_next = (idx_ff == 2'd0) ? 24'd0 : colour_ff;
      unique case (idx_ff)
         2'd0: colour_next[7:0] = b;
         2'd1: colour_next[15:8] = b;
         2'd2: colour_next[23:16] = b;
         default: ;
      endcase
      pix_done = alpha_ff ? (idx_ff == 2'd3) : (idx_ff == 2'd2);
      pix_alpha = alpha_ff ? b : 8'd0;
   end

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; comp_in = comp_ff;
      width_in = width_ff; height_in = height_ff; depth_in = depth_ff;
      alpha_in = alpha_ff; remain_in = remain_ff; pkt_in = pkt_ff;
      run_in = run_ff; idx_in = idx_ff; colour_in = colour_ff;
      mul_pend_in = 1'b0;
      v0 = 1'b0; v1 = 1'b0; r0 = '0; r1 = '0; erred = 1'b0;
      if (mul_pend_ff) remain_in = prod_ff;
      if (accept) begin
         if (phase_ff == PH_RAW || phase_ff == PH_PKTPIX) begin
            colour_in = colour_next;
            idx_in = pix_done ? 2'd0 : idx_ff + 2'd1;
         end
         r0.kind = KIND_PIXEL;
         r0.red = colour_next[23:16];
         r0.green = colour_next[15:8];
         r0.blue = colour_next[7:0];
         r0.alpha = pix_alpha;
         r0.has_alpha = alpha_ff;
         r0.repeat_res = 8'd1;
         unique case (phase_ff)
            PH_SIG: begin
               if (pos_ff == 4'd2) comp_in = (b == TYPE_RLE);
               if ((pos_ff == 4'd2) ? !(b == TYPE_RAW || b == TYPE_RLE) : (b != 8'd0))
               begin
                  v0 = 1'b1; r0 = error_rsp(ST_BAD_SIG); erred = 1'b1;
                  phase_in = PH_ERR;
               end else if (pos_ff == SIG_LAST) begin
                  pos_in = '0; phase_in = PH_HDR;
               end else pos_in = pos_ff + 4'd1;
            end
            PH_HDR: begin
               unique case (pos_ff[2:0])
                  3'd0: width_in = {8'd0, b};
                  3'd1: width_in = {b, width_ff[7:0]};
                  3'd2: height_in = {8'd0, b};
                  3'd3: height_in = {b, height_ff[7:0]};
                  3'd4: depth_in = b;
                  default: ;
               endcase
               if (pos_ff[2:0] == HDR_LAST) begin
                  pos_in = '0;
                  if (width_ff == 16'd0 || height_ff == 16'd0 ||
                      (depth_ff != DEPTH_24 && depth_ff != DEPTH_32)) begin
                     v0 = 1'b1; r0 = error_rsp(ST_BAD_SIZE); erred = 1'b1;
                     phase_in = PH_ERR;
                  end else begin
                     alpha_in = (depth_ff == DEPTH_32);
                     mul_pend_in = 1'b1;
                     idx_in = 2'd0;
                     v0 = 1'b1; r0 = '0;
                     r0.kind = KIND_HEADER;
                     r0.image_width = width_ff;
                     r0.image_height = height_ff;
                     r0.has_alpha = (depth_ff == DEPTH_32);
                     phase_in = comp_ff ? PH_PKTHDR : PH_RAW;
                  end
               end else pos_in = pos_ff + 4'd1;
            end
            PH_RAW: if (pix_done) begin
               remain_in = remain_ff - 32'd1;
               v0 = 1'b1;
               r0.image_done = (remain_ff == 32'd1);
               if (remain_ff == 32'd1) phase_in = PH_DONE;
            end
            PH_PKTHDR: begin
               run_in = b[7];
               pkt_in = b[7] ? b - RUN_BIAS : b + 8'd1;
               idx_in = 2'd0;
               phase_in = PH_PKTPIX;
            end
            PH_PKTPIX: if (pix_done) begin
               if (run_ff) begin
                  if ({24'd0, pkt_ff} > remain_ff) begin
                     v0 = 1'b1; r0 = error_rsp(ST_OVERFLOW); erred = 1'b1;
                     phase_in = PH_ERR;
                  end else begin
                     remain_in = remain_ff - {24'd0, pkt_ff};
                     v0 = 1'b1;
                     r0.repeat_res = pkt_ff;
                     r0.image_done = (remain_ff == {24'd0, pkt_ff});
                     pkt_in = 8'd0;
                     phase_in = r0.image_done ? PH_DONE : PH_PKTHDR;
                  end
               end else if (remain_ff == 32'd0) begin
                  v0 = 1'b1; r0 = error_rsp(ST_OVERFLOW); erred = 1'b1;
                  phase_in = PH_ERR;
               end else begin
                  remain_in = remain_ff - 32'd1;
                  pkt_in = pkt_ff - 8'd1;
                  v0 = 1'b1;
                  r0.image_done = (remain_ff == 32'd1 && pkt_ff == 8'd1);
                  if (pkt_ff == 8'd1) phase_in = r0.image_done ? PH_DONE : PH_PKTHDR;
               end
            end
            default: ;
         endcase
         if (eof) begin
            if (!erred && phase_in != PH_DONE && phase_in != PH_ERR) begin
               if (v0) begin
                  v1 = 1'b1; r1 = error_rsp(ST_TRUNCATED);
               end else begin
                  v0 = 1'b1; r0 = error_rsp(ST_TRUNCATED);
               end
            end
            phase_in = PH_SIG; pos_in = '0; comp_in = 1'b0;
            width_in = '0; height_in = '0; depth_in = '0; alpha_in = 1'b0;
            remain_in = '0; pkt_in = '0; run_in = 1'b0; idx_in = '0;
            colour_in = '0; mul_pend_in = 1'b0;
         end
         if (v1) r1.last_of_input = 1'b1;
         else r0.last_of_input = 1'b1;
      end
   end

   assign job_valid = accept && v0;
   always_comb begin
      job.first_vld = v0;
      job.first = r0;
      job.second_vld = v1;
      job.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG; pos_ff <= '0; comp_ff <= 1'b0;
         width_ff <= '0; height_ff <= '0; depth_ff <= '0; alpha_ff <= 1'b0;
         remain_ff <= '0; pkt_ff <= '0; run_ff <= 1'b0; idx_ff <= '0;
         colour_ff <= '0; mul_pend_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; comp_ff <= comp_in;
         width_ff <= width_in; height_ff <= height_in; depth_ff <= depth_in;
         alpha_ff <= alpha_in; remain_ff <= remain_in; pkt_ff <= pkt_in;
         run_ff <= run_in; idx_ff <= idx_in; colour_ff <= colour_in;
         mul_pend_ff <= mul_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= {16'd0, width_ff} * {16'd0, height_ff};
   end
endmodule

### sv/tga_queue.sv
`timescale 1ns / 1ps
module tga_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tga_pkg::job_type  push_job,
   output logic              can_push,
   output logic              pop_valid,
   input  logic              pop,
   output tga_pkg::job_type  pop_job
);
   import tga_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign can_push = (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop) rd_ff <= rd_ff + QPTR_W'(1);
         cnt_ff <= cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end
endmodule

### sv/tga_back.sv
`timescale 1ns / 1ps
module tga_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  tga_pkg::job_type  job,
   output logic              out_valid,
   input  logic              out_ready,
   output tga_pkg::rsp_type  out_item
);
   import tga_pkg::*;

   logic    vld_ff, vld_in;
   rsp_type data_ff, data_in;
   logic    second_ff, second_in;
   logic    load;

   assign out_valid = vld_ff;
   assign out_item = data_ff;
   assign load = !vld_ff || out_ready;

   always_comb begin
      vld_in = vld_ff; data_in = data_ff; second_in = second_ff; job_pop = 1'b0;
      if (load) begin
         vld_in = 1'b0;
         if (job_valid) begin
            vld_in = 1'b1;
            if (second_ff) begin
               data_in = job.second; second_in = 1'b0; job_pop = 1'b1;
            end else begin
               data_in = job.first;
               if (job.second_vld) second_in = 1'b1;
               else job_pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; second_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in; second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule

### sv/tga_rle_image_decoder_top.sv
`timescale 1ns / 1ps
// A byte's first result is registered in the queue and then in the output register before it reaches rsp.
// Throughput: one byte per cycle while the queue has room; the byte after the
// header is held while the width*height product is loaded. A byte giving two
// results sends them one after the other; a four-entry queue absorbs this.
// Reset: synchronous, active high; parser to signature wait, queue empty.
module tga_rle_image_decoder_top (
   input logic   clock,
   input logic   reset,
   tga_req_if.sink   req,
   tga_rsp_if.source rsp
);
   import tga_pkg::*;

   logic    f_valid, q_can, q_valid, q_pop;
   job_type f_job, q_job;

   tga_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req.payload),
      .job_valid(f_valid), .job_ready(q_can), .job(f_job)
   );

   tga_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_job(f_job), .can_push(q_can),
      .pop_valid(q_valid), .pop(q_pop), .pop_job(q_job)
   );

   tga_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_pop(q_pop), .job(q_job),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(rsp.payload)
   );
endmodule
